>>> sv/apq_pkg.sv
// Shared types and constants for the unsorted-array minimum priority queue.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package apq_pkg;

	localparam int unsigned DEPTH_DEF    = 16;
	localparam int unsigned KEY_BITS_DEF = 16;
	localparam int unsigned PAYLOAD_BITS = 32;
	localparam int unsigned CNT_BITS     = 5;

	localparam logic [CNT_BITS-1:0] CAP_RESET = CNT_BITS'(16);

	// Operation codes; the unused code falls through to peek.
	typedef enum logic [1:0] {
		FN_INSERT = 2'd0,
		FN_PEEK   = 2'd1,
		FN_REMOVE = 2'd2
	} func_t;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_FULL     = 2'd1,
		ST_RETURNED = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_PICK,
		S_SWAP_A,
		S_SWAP_B,
		S_FINISH
	} state_t;

	// Control of the shared compare unit.
	typedef struct packed {
		logic en;
		logic first;
	} scan_ctl_t;

endpackage

`default_nettype wire

>>> sv/apq_if.sv
// Valid/ready channel interfaces for requests and responses of the queue.
// Depends on apq_pkg.
`default_nettype none

interface apq_req_if #(
	parameter int unsigned KEY_BITS = apq_pkg::KEY_BITS_DEF
);
	logic                            valid;
	logic                            ready;
	logic [1:0]                      func;
	logic [KEY_BITS-1:0]             key;
	logic [apq_pkg::PAYLOAD_BITS-1:0] payload;

	modport source (output valid, func, key, payload, input ready);
	modport sink   (input valid, func, key, payload, output ready);
endinterface

interface apq_rsp_if #(
	parameter int unsigned KEY_BITS = apq_pkg::KEY_BITS_DEF
);
	logic                             valid;
	logic                             ready;
	apq_pkg::status_t                 status;
	logic [KEY_BITS-1:0]              out_key;
	logic [apq_pkg::PAYLOAD_BITS-1:0] out_payload;
	logic [apq_pkg::CNT_BITS-1:0]     occupancy;

	modport source (output valid, status, out_key, out_payload, occupancy, input ready);
	modport sink   (input valid, status, out_key, out_payload, occupancy, output ready);
endinterface

`default_nettype wire

>>> sv/apq_store.sv
// Entry memory: key and payload arrays, one write port, one registered read port.
// Depends on apq_pkg.
`default_nettype none

module apq_store #(
	parameter int unsigned DEPTH    = apq_pkg::DEPTH_DEF,
	parameter int unsigned KEY_BITS = apq_pkg::KEY_BITS_DEF,
	localparam int unsigned AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                             clk,
	input  wire logic                             wr_en,
	input  wire logic [AW-1:0]                    wr_addr,
	input  wire logic [KEY_BITS-1:0]              wr_key,
	input  wire logic [apq_pkg::PAYLOAD_BITS-1:0] wr_payload,
	input  wire logic                             rd_en,
	input  wire logic [AW-1:0]                    rd_addr,
	output logic      [KEY_BITS-1:0]              rd_key,
	output logic      [apq_pkg::PAYLOAD_BITS-1:0] rd_payload
);

	logic [KEY_BITS-1:0]              key_mem [DEPTH];
	logic [apq_pkg::PAYLOAD_BITS-1:0] pay_mem [DEPTH];
	logic [KEY_BITS-1:0]              rd_key_q;
	logic [apq_pkg::PAYLOAD_BITS-1:0] rd_payload_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= wr_key;
			pay_mem[wr_addr] <= wr_payload;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_key_q     <= key_mem[rd_addr];
			rd_payload_q <= pay_mem[rd_addr];
		end
	end

	assign rd_key     = rd_key_q;
	assign rd_payload = rd_payload_q;

endmodule

`default_nettype wire

>>> sv/apq_scan.sv
// Shared compare unit: keeps the running minimum over one entry per cycle.
// Depends on apq_pkg.
`default_nettype none

module apq_scan #(
	parameter int unsigned KEY_BITS = apq_pkg::KEY_BITS_DEF,
	parameter int unsigned AW       = 4
) (
	input  wire logic                             clk,
	input  wire apq_pkg::scan_ctl_t               ctl,
	input  wire logic [KEY_BITS-1:0]              cand_key,
	input  wire logic [apq_pkg::PAYLOAD_BITS-1:0] cand_payload,
	input  wire logic [AW-1:0]                    cand_pos,
	output logic      [KEY_BITS-1:0]              best_key,
	output logic      [apq_pkg::PAYLOAD_BITS-1:0] best_payload,
	output logic      [AW-1:0]                    best_pos
);

	logic [KEY_BITS-1:0]              best_key_q;
	logic [apq_pkg::PAYLOAD_BITS-1:0] best_payload_q;
	logic [AW-1:0]                    best_pos_q;
	logic                             take;

	// Strict compare: on a tie the earlier position stays.
	assign take = ctl.en && (ctl.first || (cand_key < best_key_q));

	always_ff @(posedge clk) begin
		if (take) begin
			best_key_q     <= cand_key;
			best_payload_q <= cand_payload;
			best_pos_q     <= cand_pos;
		end
	end

	assign best_key     = best_key_q;
	assign best_payload = best_payload_q;
	assign best_pos     = best_pos_q;

endmodule

`default_nettype wire

>>> sv/unsorted_array_priority_queue_core.sv
// Top level of the minimum priority queue kept as an unordered entry array.
// Depends on apq_pkg, apq_if, apq_store and apq_scan.
`default_nettype none

// Channel   Dir  Handshake          Content
// req       in   valid/ready        func, key, payload
// rsp       out  valid/ready        status, out_key, out_payload, occupancy
// cfg       in   cfg_wr_en only     cfg_wr_data = capacity
//
// Insert and an operation on an empty queue go from transfer straight to
// S_FINISH, which loads the response register. Other requests first pass
// S_SCAN over the N stored entries, then S_PICK: the single compare unit sees one entry per
// cycle, fed by the single read port of the entry memory, and remove spends
// one read and two writes on the swap in S_SWAP_A and S_SWAP_B. One request is in flight at a time.
// Reset clears the count, the capacity (to 16) and the response valid; the
// entry memory needs no clearing since only written slots are ever read.
// A stalled response holds in its register; the next request is taken meanwhile.

module unsorted_array_priority_queue_core #(
	parameter int unsigned DEPTH    = apq_pkg::DEPTH_DEF,
	parameter int unsigned KEY_BITS = apq_pkg::KEY_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	apq_req_if.sink                           req,
	apq_rsp_if.source                         rsp,
	input  wire logic                         cfg_wr_en,
	input  wire logic [apq_pkg::CNT_BITS-1:0] cfg_wr_data
);

	localparam int unsigned AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW        = apq_pkg::CNT_BITS;
	localparam int unsigned PW        = apq_pkg::PAYLOAD_BITS;
	// Count never passes the 5-bit capacity, so the depth limit saturates there.
	localparam int unsigned DEPTH_SAT = (DEPTH > ((1 << CW) - 1)) ? ((1 << CW) - 1) : DEPTH;
	localparam logic [CW-1:0] DEPTH_LIM = CW'(DEPTH_SAT);

	apq_pkg::state_t  state_q, state_d;
	apq_pkg::status_t status_q;

	logic [CW-1:0]   count_q;
	logic [CW-1:0]   cap_q;
	logic [CW-1:0]   idx_q;
	logic            is_remove_q;

	logic            rsp_valid_q;
	apq_pkg::status_t rsp_status_q;
	logic [KEY_BITS-1:0] rsp_key_q;
	logic [PW-1:0]   rsp_payload_q;
	logic [CW-1:0]   rsp_occ_q;

	logic            req_xfer;
	logic            is_insert;
	logic            ins_ok;
	logic            rsp_free;
	logic [CW-1:0]   last_idx;

	// memory and compare unit hookup
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic [KEY_BITS-1:0] mem_wkey;
	logic [PW-1:0]       mem_wpay;
	logic                mem_re;
	logic [AW-1:0]       mem_raddr;
	logic [KEY_BITS-1:0] rd_key;
	logic [PW-1:0]       rd_payload;

	apq_pkg::scan_ctl_t  scan_ctl;
	logic [AW-1:0]       scan_pos;
	logic [KEY_BITS-1:0] best_key;
	logic [PW-1:0]       best_payload;
	logic [AW-1:0]       best_pos;

	assign req.ready = (state_q == apq_pkg::S_IDLE);
	assign req_xfer  = req.valid && req.ready;
	assign is_insert = (req.func == apq_pkg::FN_INSERT);
	assign ins_ok    = (count_q < cap_q) && (count_q < DEPTH_LIM);
	assign rsp_free  = !rsp_valid_q || rsp.ready;
	assign last_idx  = CW'(count_q - 1'b1);
	assign scan_pos  = AW'(CW'(idx_q - 1'b1));

	apq_store #(
		.DEPTH    (DEPTH),
		.KEY_BITS (KEY_BITS)
	) u_store (
		.clk        (clk),
		.wr_en      (mem_we),
		.wr_addr    (mem_waddr),
		.wr_key     (mem_wkey),
		.wr_payload (mem_wpay),
		.rd_en      (mem_re),
		.rd_addr    (mem_raddr),
		.rd_key     (rd_key),
		.rd_payload (rd_payload)
	);

	apq_scan #(
		.KEY_BITS (KEY_BITS),
		.AW       (AW)
	) u_scan (
		.clk          (clk),
		.ctl          (scan_ctl),
		.cand_key     (rd_key),
		.cand_payload (rd_payload),
		.cand_pos     (scan_pos),
		.best_key     (best_key),
		.best_payload (best_payload),
		.best_pos     (best_pos)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			apq_pkg::S_IDLE: begin
				if (req_xfer) begin
					if (is_insert || (count_q == '0))
						state_d = apq_pkg::S_FINISH;
					else
						state_d = apq_pkg::S_SCAN;
				end
			end
			apq_pkg::S_SCAN: begin
				if (idx_q >= count_q)
					state_d = apq_pkg::S_PICK;
			end
			apq_pkg::S_PICK: begin
				state_d = is_remove_q ? apq_pkg::S_SWAP_A : apq_pkg::S_FINISH;
			end
			apq_pkg::S_SWAP_A: state_d = apq_pkg::S_SWAP_B;
			apq_pkg::S_SWAP_B: state_d = apq_pkg::S_FINISH;
			apq_pkg::S_FINISH: begin
				if (rsp_free)
					state_d = apq_pkg::S_IDLE;
			end
			default: state_d = apq_pkg::S_IDLE;
		endcase
	end

	// Memory and compare unit controls per state
	always_comb begin
		mem_we         = 1'b0;
		mem_waddr      = AW'(count_q);
		mem_wkey       = req.key;
		mem_wpay       = req.payload;
		mem_re         = 1'b0;
		mem_raddr      = AW'(idx_q);
		scan_ctl.en    = 1'b0;
		scan_ctl.first = 1'b0;
		unique case (state_q)
			apq_pkg::S_IDLE: begin
				// append on insert; start the scan at entry zero otherwise
				mem_we    = req_xfer && is_insert && ins_ok;
				mem_re    = req_xfer && !is_insert;
				mem_raddr = '0;
			end
			apq_pkg::S_SCAN: begin
				scan_ctl.en    = 1'b1;
				scan_ctl.first = (idx_q == CW'(1));
				mem_re         = (idx_q < count_q);
			end
			apq_pkg::S_PICK: begin
				// fetch the last entry for the swap
				mem_re    = is_remove_q;
				mem_raddr = AW'(last_idx);
			end
			apq_pkg::S_SWAP_A: begin
				mem_we    = 1'b1;
				mem_waddr = best_pos;
				mem_wkey  = rd_key;
				mem_wpay  = rd_payload;
			end
			apq_pkg::S_SWAP_B: begin
				mem_we    = 1'b1;
				mem_waddr = AW'(last_idx);
				mem_wkey  = best_key;
				mem_wpay  = best_payload;
			end
			apq_pkg::S_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	// Control state: sequencer, entry count, capacity, response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= apq_pkg::S_IDLE;
			count_q     <= '0;
			cap_q       <= apq_pkg::CAP_RESET;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en)
				cap_q <= cfg_wr_data;
			if (req_xfer && is_insert && ins_ok)
				count_q <= CW'(count_q + 1'b1);
			else if (state_q == apq_pkg::S_SWAP_B)
				count_q <= last_idx;
			if ((state_q == apq_pkg::S_FINISH) && rsp_free)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

	// Datapath registers: scan index, operation, status, response payload
	always_ff @(posedge clk) begin
		if (req_xfer) begin
			idx_q       <= CW'(1);
			is_remove_q <= (req.func == apq_pkg::FN_REMOVE);
			if (is_insert)
				status_q <= ins_ok ? apq_pkg::ST_INSERTED : apq_pkg::ST_FULL;
			else if (count_q == '0)
				status_q <= apq_pkg::ST_EMPTY;
			else
				status_q <= apq_pkg::ST_RETURNED;
		end else if ((state_q == apq_pkg::S_SCAN) && (idx_q < count_q)) begin
			idx_q <= CW'(idx_q + 1'b1);
		end
		if ((state_q == apq_pkg::S_FINISH) && rsp_free) begin
			rsp_status_q <= status_q;
			rsp_occ_q    <= count_q;
			if (status_q == apq_pkg::ST_RETURNED) begin
				rsp_key_q     <= best_key;
				rsp_payload_q <= best_payload;
			end else begin
				rsp_key_q     <= '0;
				rsp_payload_q <= '0;
			end
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.out_key     = rsp_key_q;
	assign rsp.out_payload = rsp_payload_q;
	assign rsp.occupancy   = rsp_occ_q;

endmodule

`default_nettype wire

>>> sv/apq_checker.sv
// Port-level checks for the priority queue, bound onto the top level.
// Depends on apq_pkg and unsorted_array_priority_queue_core.
`default_nettype none

module apq_checker #(
	parameter int unsigned KEY_BITS = apq_pkg::KEY_BITS_DEF
) (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             req_valid,
	input wire logic                             req_ready,
	input wire logic                             rsp_valid,
	input wire logic                             rsp_ready,
	input wire apq_pkg::status_t                 rsp_status,
	input wire logic [KEY_BITS-1:0]              rsp_key,
	input wire logic [apq_pkg::PAYLOAD_BITS-1:0] rsp_payload,
	input wire logic [apq_pkg::CNT_BITS-1:0]     rsp_occ
);

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
			$stable(rsp_key) && $stable(rsp_payload) && $stable(rsp_occ))
		else $error("stalled response changed");

	// one request in flight: ready drops after each transfer
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while busy");

	a_insert_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == apq_pkg::ST_INSERTED) |-> rsp_occ != '0)
		else $error("insert left queue empty");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == apq_pkg::ST_EMPTY) |-> rsp_occ == '0)
		else $error("empty reported with entries stored");

	a_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != apq_pkg::ST_RETURNED) |->
			(rsp_key == '0) && (rsp_payload == '0))
		else $error("nonzero data without a returned entry");

endmodule

bind unsorted_array_priority_queue_core apq_checker #(
	.KEY_BITS (KEY_BITS)
) u_apq_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_status  (rsp.status),
	.rsp_key     (rsp.out_key),
	.rsp_payload (rsp.out_payload),
	.rsp_occ     (rsp.occupancy)
);

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 100ps
// Testbench for unsorted_array_priority_queue_core: directed and random queue operations.
// A local queue model predicts each response. Depends on apq_pkg, apq_if and the core RTL.

module tb_top;
	import apq_pkg::*;

	localparam int unsigned Q_DEPTH = DEPTH_DEF;
	// The fourth operation code has no package name; the core treats it as a peek.
	localparam logic [1:0] FN_SPARE = 2'd3;

	typedef struct {
		logic [1:0]  func;
		logic [15:0] key;
		logic [31:0] payload;
	} queue_op_t;

	typedef struct {
		status_t     status;
		logic [15:0] key;
		logic [31:0] payload;
		logic [4:0]  occupancy;
	} queue_answer_t;

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [4:0] cfg_wr_data;

	apq_req_if #(.KEY_BITS(KEY_BITS_DEF)) req_ch ();
	apq_rsp_if #(.KEY_BITS(KEY_BITS_DEF)) rsp_ch ();

	unsorted_array_priority_queue_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req_ch),
		.rsp        (rsp_ch),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// Model state: entries, count and the capacity last written.
	logic [15:0]   slot_key [Q_DEPTH];
	logic [31:0]   slot_pay [Q_DEPTH];
	int unsigned   stored = 0;
	logic [4:0]    cap_now = CAP_RESET;

	queue_op_t     op_backlog [$];
	queue_answer_t answers [$];
	int unsigned   ops_offered = 0;
	int unsigned   ops_taken = 0;
	int unsigned   fail_count = 0;
	int unsigned   send_gap = 0;
	int unsigned   stall_left = 0;
	bit            calm_phase = 0;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Apply one operation to the model and return the response it must produce.
	function automatic queue_answer_t apply_queue_op(queue_op_t op);
		queue_answer_t ans;
		int unsigned   room;
		int unsigned   best;
		ans.status  = ST_EMPTY;
		ans.key     = '0;
		ans.payload = '0;
		// Capacity above the array depth saturates at the depth.
		room = (cap_now > Q_DEPTH) ? Q_DEPTH : cap_now;
		if (op.func == FN_INSERT) begin
			if (stored < room) begin
				slot_key[stored] = op.key;
				slot_pay[stored] = op.payload;
				stored++;
				ans.status = ST_INSERTED;
			end else begin
				ans.status = ST_FULL;
			end
		end else if (stored != 0) begin
			// Strict less-than keeps the lowest position on equal keys.
			best = 0;
			for (int unsigned i = 1; i < stored; i++) begin
				if (slot_key[i] < slot_key[best])
					best = i;
			end
			ans.status  = ST_RETURNED;
			ans.key     = slot_key[best];
			ans.payload = slot_pay[best];
			// Only remove changes the array; peek and the spare code leave it alone.
			if (op.func == FN_REMOVE) begin
				slot_key[best] = slot_key[stored-1];
				slot_pay[best] = slot_pay[stored-1];
				stored--;
			end
		end
		ans.occupancy = 5'(stored);
		return ans;
	endfunction

	// Draw a random operation; keys lean toward a narrow range so ties are common.
	function automatic queue_op_t draw_queue_op(int unsigned insert_pct);
		queue_op_t   op;
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < insert_pct)
			op.func = FN_INSERT;
		else if (roll < insert_pct + 4)
			op.func = FN_SPARE;
		else if ($urandom_range(99) < 35)
			op.func = FN_PEEK;
		else
			op.func = FN_REMOVE;
		roll = $urandom_range(99);
		if (roll < 40)
			op.key = 16'($urandom_range(7));
		else if (roll < 50)
			op.key = $urandom_range(1) ? 16'hFFFF : 16'h0000;
		else
			op.key = 16'($urandom);
		op.payload = $urandom;
		return op;
	endfunction

	// Pause length for either side: mostly none or short, now and then long.
	function automatic int unsigned draw_pause();
		int unsigned roll;
		roll = $urandom_range(99);
		if (calm_phase || roll < 60)
			return 0;
		else if (roll < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(4, 40);
	endfunction

	// Request driver: present the next backlog entry once the previous transfer is done.
	always @(negedge clk) begin
		queue_op_t op;
		if (arst_n) begin
			if (!req_ch.valid || ops_taken == ops_offered) begin
				if (send_gap > 0) begin
					send_gap--;
					req_ch.valid <= 1'b0;
				end else if (op_backlog.size() > 0) begin
					op = op_backlog.pop_front();
					req_ch.func    <= op.func;
					req_ch.key     <= op.key;
					req_ch.payload <= op.payload;
					req_ch.valid   <= 1'b1;
					ops_offered++;
					send_gap = draw_pause();
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Response ready: hold high, drop it for random stretches.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
			if ($urandom_range(99) < 15)
				stall_left = draw_pause();
		end
	end

	// Check each response transfer against the oldest prediction, then
	// predict for a request transfer at the same edge.
	always @(posedge clk) begin
		queue_answer_t want;
		if (arst_n) begin
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				if (answers.size() == 0) begin
					$error("response transfer with no prediction pending");
					fail_count++;
				end else begin
					want = answers.pop_front();
					if (rsp_ch.status !== want.status) begin
						$error("status expected %0d actual %0d", want.status, rsp_ch.status);
						fail_count++;
					end
					if (rsp_ch.out_key !== want.key) begin
						$error("out_key expected %0h actual %0h", want.key, rsp_ch.out_key);
						fail_count++;
					end
					if (rsp_ch.out_payload !== want.payload) begin
						$error("out_payload expected %0h actual %0h",
							want.payload, rsp_ch.out_payload);
						fail_count++;
					end
					if (rsp_ch.occupancy !== want.occupancy) begin
						$error("occupancy expected %0d actual %0d",
							want.occupancy, rsp_ch.occupancy);
						fail_count++;
					end
				end
			end
			if (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) begin
				answers.push_back(apply_queue_op('{req_ch.func, req_ch.key, req_ch.payload}));
				ops_taken++;
			end
		end
	end

	task automatic queue_directed(logic [1:0] func, logic [15:0] key, logic [31:0] payload);
		op_backlog.push_back('{func, key, payload});
	endtask

	// Wait until every request is taken and every response is back, then hold off briefly.
	task automatic drain_queue();
		while (op_backlog.size() != 0 || ops_taken != ops_offered || answers.size() != 0)
			@(negedge clk);
		repeat ($urandom_range(1, 6)) @(negedge clk);
	endtask

	// Write the capacity register; only called with the core idle.
	task automatic set_capacity(logic [4:0] value);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		cap_now = value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Random phases: capacity (-1 draws one), length, insert share, no-pause flag.
	int phase_cap   [12] = '{31,   3,  16,  0,  17,  1,  -1,   8,   2,  -1,  16,  -1};
	int phase_len   [12] = '{130, 110, 120, 60, 130, 90, 120, 120, 100, 130, 140, 150};
	int phase_ins   [12] = '{75,  40,  55,  50,  70, 50,  55,  65,  45,  60,  50,  50};
	bit phase_calm  [12] = '{0,   0,   1,   0,   0,  0,   0,   1,   0,   0,   0,   0};

	initial begin
		arst_n         = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_wr_data    = '0;
		req_ch.valid   = 1'b0;
		req_ch.func    = FN_PEEK;
		req_ch.key     = '0;
		req_ch.payload = '0;
		rsp_ch.ready   = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Empty queue on every lookup code, then extremes, ties and the swap on remove.
		queue_directed(FN_PEEK, 16'h0000, 32'h0);
		queue_directed(FN_REMOVE, 16'h0000, 32'h0);
		queue_directed(FN_SPARE, 16'h0000, 32'h0);
		queue_directed(FN_INSERT, 16'hFFFF, 32'hFFFF_FFFF);
		queue_directed(FN_INSERT, 16'h0000, 32'h0000_0000);
		queue_directed(FN_INSERT, 16'h8000, 32'hA5A5_A5A5);
		queue_directed(FN_INSERT, 16'h0000, 32'h1234_5678);
		queue_directed(FN_PEEK, 16'hFFFF, 32'hFFFF_FFFF);
		queue_directed(FN_SPARE, 16'h0000, 32'h0);
		queue_directed(FN_REMOVE, 16'h0000, 32'h0);
		queue_directed(FN_PEEK, 16'h0000, 32'h0);
		repeat (4) queue_directed(FN_REMOVE, 16'h0000, 32'h0);
		queue_directed(FN_PEEK, 16'h0000, 32'h0);
		drain_queue();

		// Zero capacity refuses every insert.
		set_capacity(5'd0);
		queue_directed(FN_INSERT, 16'h0001, 32'h0000_0001);
		queue_directed(FN_INSERT, 16'h0002, 32'h0000_0002);
		queue_directed(FN_PEEK, 16'h0000, 32'h0);
		drain_queue();

		// Capacity two: the third insert reports full.
		set_capacity(5'd2);
		queue_directed(FN_INSERT, 16'h0030, 32'hDEAD_BEEF);
		queue_directed(FN_INSERT, 16'h0010, 32'hCAFE_F00D);
		queue_directed(FN_INSERT, 16'h0020, 32'h0BAD_F00D);
		queue_directed(FN_REMOVE, 16'h0000, 32'h0);
		drain_queue();

		// Random phases; each boundary waits for all responses before the write.
		foreach (phase_cap[p]) begin
			calm_phase = phase_calm[p];
			set_capacity(phase_cap[p] < 0 ? 5'($urandom_range(31)) : 5'(phase_cap[p]));
			repeat (phase_len[p]) op_backlog.push_back(draw_queue_op(phase_ins[p]));
			drain_queue();
		end

		// Let the core settle past its longest scan before the verdict.
		repeat (Q_DEPTH + 8) @(negedge clk);
		if (fail_count == 0)
			$display("[unsorted_array_priority_queue_core] OK");
		else
			$display("[unsorted_array_priority_queue_core] ERROR");
		$finish;
	end

	// Guard against a hang: far beyond the slowest legal run.
	initial begin
		#2000000;
		$display("[unsorted_array_priority_queue_core] ERROR");
		$finish;
	end

endmodule
